FILE: hdl/word_overlap_correlation_histogram_defines.svh
// Assertion macros shared by the histogram block.
`ifndef WORD_OVERLAP_CORRELATION_HISTOGRAM_DEFINES_SVH
`define WORD_OVERLAP_CORRELATION_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WOCH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WOCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hdl/woch_pkg.sv
`default_nettype none

package woch_pkg;

	// Default geometry
	localparam int WORD_SYMBOLS_DEF = 4;
	localparam int SYMBOL_BITS_DEF  = 2;
	localparam int COUNT_WIDTH_DEF  = 32;

	// Fixed field widths on the ports
	localparam int WORD_W      = 8;
	localparam int INDEX_W     = 12;
	localparam int CORR_W      = 3;
	localparam int BIN_COUNT_W = 33;
	localparam int TOTAL_W     = 32;
	localparam int S_FIELDS_W  = 2 * WORD_W + INDEX_W;
	localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W  = 4 * CORR_W + BIN_COUNT_W + TOTAL_W;
	localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		KIND_ADD  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture an accepted transaction
		logic clear;   // zero one histogram entry, advance the sweep
		logic rd;      // read the captured bin
		logic update;  // write back, bump total, load result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;  // sweep sits on the last entry
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

`default_nettype wire

FILE: hdl/woch_ctrl.sv
`default_nettype none

module woch_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output woch_pkg::cmd_t      cmd,
	input  wire woch_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = S_WRITE;
			end
			S_WRITE: begin
				// hold until the result register frees up
				if (sts.out_free) begin
					cmd.update = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/woch_datapath.sv
`default_nettype none

module woch_datapath #(
	parameter int WORD_SYMBOLS = woch_pkg::WORD_SYMBOLS_DEF,
	parameter int SYMBOL_BITS  = woch_pkg::SYMBOL_BITS_DEF,
	parameter int COUNT_WIDTH  = woch_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire woch_pkg::cmd_t                      cmd,
	output woch_pkg::sts_t                           sts,
	input  wire logic                                kind,
	input  wire logic [woch_pkg::WORD_W-1:0]         word_a,
	input  wire logic [woch_pkg::WORD_W-1:0]         word_b,
	input  wire logic [woch_pkg::INDEX_W-1:0]        bin_index,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic [woch_pkg::CORR_W-1:0]              corr_ab,
	output logic [woch_pkg::CORR_W-1:0]              corr_ba,
	output logic [woch_pkg::CORR_W-1:0]              corr_aa,
	output logic [woch_pkg::CORR_W-1:0]              corr_bb,
	output logic [woch_pkg::BIN_COUNT_W-1:0]         bin_count,
	output logic [woch_pkg::TOTAL_W-1:0]             pair_total,
	output logic                                     rejected
);

	localparam int VEC_BITS  = WORD_SYMBOLS - 1;
	localparam int WORD_BITS = WORD_SYMBOLS * SYMBOL_BITS;
	localparam int BIN_BITS  = 4 * VEC_BITS;
	localparam int BIN_DEPTH = 1 << BIN_BITS;
	localparam int CORR_W    = woch_pkg::CORR_W;
	localparam int BCW       = woch_pkg::BIN_COUNT_W;
	localparam int TOTAL_W   = woch_pkg::TOTAL_W;

	function automatic logic [VEC_BITS-1:0] corr_vec(
		input logic [WORD_BITS-1:0] x,
		input logic [WORD_BITS-1:0] y
	);
		logic [VEC_BITS-1:0]  vec;
		logic [WORD_BITS-1:0] ys;
		logic [WORD_BITS-1:0] msk;
		vec = '0;
		for (int s = 1; s < WORD_SYMBOLS; s++) begin
			ys  = y >> (s * SYMBOL_BITS);
			msk = {WORD_BITS{1'b1}} >> (s * SYMBOL_BITS);
			vec[VEC_BITS-s] = (((x ^ ys) & msk) == '0);
		end
		return vec;
	endfunction

	function automatic logic [CORR_W-1:0] fit_corr(input logic [VEC_BITS-1:0] v);
		logic [CORR_W+VEC_BITS-1:0] ext;
		ext = {{CORR_W{1'b0}}, v};
		return ext[CORR_W-1:0];
	endfunction

	// Word masking: drop bits above the word, or zero-extend
	logic [WORD_BITS+woch_pkg::WORD_W-1:0]  a_ext, b_ext;
	logic [WORD_BITS-1:0]                   a_w, b_w;
	logic [BIN_BITS+woch_pkg::INDEX_W-1:0]  rd_idx_ext;
	logic [VEC_BITS-1:0]                    ab, ba, aa, bb;
	logic                                   is_add, b_below;

	assign a_ext      = {{WORD_BITS{1'b0}}, word_a};
	assign b_ext      = {{WORD_BITS{1'b0}}, word_b};
	assign a_w        = a_ext[WORD_BITS-1:0];
	assign b_w        = b_ext[WORD_BITS-1:0];
	assign rd_idx_ext = {{BIN_BITS{1'b0}}, bin_index};
	assign ab         = corr_vec(a_w, b_w);
	assign ba         = corr_vec(b_w, a_w);
	assign aa         = corr_vec(a_w, a_w);
	assign bb         = corr_vec(b_w, b_w);
	assign is_add     = (woch_pkg::kind_t'(kind) == woch_pkg::KIND_ADD);
	assign b_below    = (b_w < a_w);

	// Captured transaction
	logic                 add_q, rej_q;
	logic [VEC_BITS-1:0]  ab_q, ba_q, aa_q, bb_q;
	logic [BIN_BITS-1:0]  idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			add_q <= is_add;
			rej_q <= is_add && !b_below;
			ab_q  <= is_add ? ab : '0;
			ba_q  <= is_add ? ba : '0;
			aa_q  <= is_add ? aa : '0;
			bb_q  <= is_add ? bb : '0;
			idx_q <= is_add ? {ab, ba, aa, bb} : rd_idx_ext[BIN_BITS-1:0];
		end
	end

	// Histogram memory and clearing sweep
	logic [COUNT_WIDTH-1:0] hist_mem [BIN_DEPTH];
	logic [COUNT_WIDTH-1:0] rdata_q, cnt_inc, wdata;
	logic [BIN_BITS-1:0]    clr_addr_q, waddr;
	logic                   counted, we;

	assign counted = add_q && !rej_q;
	assign cnt_inc = (&rdata_q) ? rdata_q : rdata_q + 1'b1;
	assign we      = cmd.clear || (cmd.update && counted);
	assign waddr   = cmd.clear ? clr_addr_q : idx_q;
	assign wdata   = cmd.clear ? '0 : cnt_inc;

	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= hist_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Pair total
	logic [TOTAL_W-1:0] total_q, total_nxt;

	assign total_nxt = (counted && !(&total_q)) ? total_q + 1'b1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.update) begin
			total_q <= total_nxt;
		end
	end

	// Result register
	logic [BCW+COUNT_WIDTH:0] dbl;
	logic                     out_valid_q;

	assign dbl = {{BCW{1'b0}}, rdata_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			corr_ab    <= fit_corr(ab_q);
			corr_ba    <= fit_corr(ba_q);
			corr_aa    <= fit_corr(aa_q);
			corr_bb    <= fit_corr(bb_q);
			bin_count  <= add_q ? '0 : dbl[BCW-1:0];
			pair_total <= total_nxt;
			rejected   <= rej_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.clr_last = (&clr_addr_q);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

FILE: hdl/word_overlap_correlation_histogram.sv
// Channel  | Direction | tdata fields, lowest bit first                       | tuser
// s_axis   | in        | word_a[7:0] word_b[15:8] bin_index[27:16] zero[31:28] | kind
// m_axis   | out       | corr_ab[2:0] corr_ba[5:3] corr_aa[8:6] corr_bb[11:9]  | rejected
//          |           | bin_count[44:12] pair_total[76:45] zero[79:77]       |
//
// After reset the histogram memory is swept to zero, one entry per cycle, through all
// 2^(4*(WORD_SYMBOLS-1)) entries, 4096 at the default geometry. No input is taken meanwhile.
// Each transaction then goes through capture, memory read and write-back, as the
// read-modify-write of the single histogram memory needs; input waits until write-back.
// A finished result sits in the output register; the next input is accepted while it waits,
// and only the write-back stage holds when m_axis_tready stays low.
`default_nettype none
`include "word_overlap_correlation_histogram_defines.svh"

module word_overlap_correlation_histogram #(
	parameter int WORD_SYMBOLS = woch_pkg::WORD_SYMBOLS_DEF,
	parameter int SYMBOL_BITS  = woch_pkg::SYMBOL_BITS_DEF,
	parameter int COUNT_WIDTH  = woch_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// word_a, word_b, bin_index, zero pad
	input  wire logic [woch_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// kind
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// corr_ab, corr_ba, corr_aa, corr_bb, bin_count, pair_total, zero pad
	output logic [woch_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// rejected
	output logic                                  m_axis_tuser
);

	localparam int WORD_W  = woch_pkg::WORD_W;
	localparam int INDEX_W = woch_pkg::INDEX_W;
	localparam int M_PAD_W = woch_pkg::M_TDATA_W - woch_pkg::M_FIELDS_W;

	woch_pkg::cmd_t cmd;
	woch_pkg::sts_t sts;

	// Unpack the input transaction
	logic [WORD_W-1:0]  word_a, word_b;
	logic [INDEX_W-1:0] bin_index;

	assign word_a    = s_axis_tdata[WORD_W-1:0];
	assign word_b    = s_axis_tdata[2*WORD_W-1:WORD_W];
	assign bin_index = s_axis_tdata[2*WORD_W+INDEX_W-1:2*WORD_W];

	logic [woch_pkg::CORR_W-1:0]      corr_ab, corr_ba, corr_aa, corr_bb;
	logic [woch_pkg::BIN_COUNT_W-1:0] bin_count;
	logic [woch_pkg::TOTAL_W-1:0]     pair_total;
	logic                             rejected;

	woch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	woch_datapath #(
		.WORD_SYMBOLS (WORD_SYMBOLS),
		.SYMBOL_BITS  (SYMBOL_BITS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (s_axis_tuser),
		.word_a     (word_a),
		.word_b     (word_b),
		.bin_index  (bin_index),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.corr_ab    (corr_ab),
		.corr_ba    (corr_ba),
		.corr_aa    (corr_aa),
		.corr_bb    (corr_bb),
		.bin_count  (bin_count),
		.pair_total (pair_total),
		.rejected   (rejected)
	);

	// Pack the result transaction
	assign m_axis_tdata = {{M_PAD_W{1'b0}}, pair_total, bin_count,
	                       corr_bb, corr_aa, corr_ba, corr_ab};
	assign m_axis_tuser = rejected;

	// Never take an item while the memory is being swept
	`WOCH_ASSERT_IMPLIES(a_no_accept_in_clear, clk, arst_n, cmd.clear, !s_axis_tready)
	// Never overwrite a result that is still waiting
	`WOCH_ASSERT_IMPLIES(a_no_result_overwrite, clk, arst_n, cmd.update, sts.out_free)
	// Capture is always followed by the memory read
	`WOCH_ASSERT_NEXT(a_read_after_load, clk, arst_n, cmd.load, cmd.rd)

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for word_overlap_correlation_histogram.
//
// Word pairs and bin reads go in on s_axis. Each accepted transaction is run through a
// local copy of the histogram and pair total. That copy works out the four
// overlap-correlation vectors, the bin update, the doubled bin count and the running total.
// The expected result is queued, and each result taken on m_axis is compared
// field by field with the oldest entry.
module testbench;
	import woch_pkg::*;

	// Geometry of the block under test
	localparam int SYMS      = WORD_SYMBOLS_DEF;
	localparam int SBITS     = SYMBOL_BITS_DEF;
	localparam int VEC_W     = SYMS - 1;
	localparam int WORD_BITS = SYMS * SBITS;
	localparam int WORD_MASK = (1 << WORD_BITS) - 1;
	localparam int BIN_W     = 4 * VEC_W;
	localparam int BINS      = 1 << BIN_W;
	localparam int TALLY_W   = COUNT_WIDTH_DEF;

	// Time limit for this run, including the clearing sweep after reset.
	localparam longint RUN_LIMIT = 4_000_000;

	// One result as it appears on m_axis
	typedef struct {
		logic [CORR_W-1:0]      corr_ab;
		logic [CORR_W-1:0]      corr_ba;
		logic [CORR_W-1:0]      corr_aa;
		logic [CORR_W-1:0]      corr_bb;
		logic [BIN_COUNT_W-1:0] bin_count;
		logic [TOTAL_W-1:0]     pair_total;
		logic                   rejected;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;

	// Local copy of the block's state
	logic [TALLY_W-1:0] bin_tally [BINS];
	logic [TOTAL_W-1:0] pairs_seen;
	logic [BIN_W-1:0]   busy_bins [$];   // bins hit at least once, for reads
	outcome_t           outcomes_due [$];
	int                 fail_count = 0;

	// Idle controls for the sender task and the receiver process
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold    = 0;   // forced output stall, counted down by the receiver

	word_overlap_correlation_histogram i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset, then release it away from the active edge
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#(RUN_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	// Receiver: a forced hold comes first, then random idle bursts
	initial begin : receiver
		int gap;
		gap = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				gap--;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				gap = $urandom_range(1, 10) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare every result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (outcomes_due.size() == 0) begin
				$error("result transaction with no prediction waiting: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("corr_ab", 64'(want.corr_ab), 64'(m_axis_tdata[2:0]));
				check_field("corr_ba", 64'(want.corr_ba), 64'(m_axis_tdata[5:3]));
				check_field("corr_aa", 64'(want.corr_aa), 64'(m_axis_tdata[8:6]));
				check_field("corr_bb", 64'(want.corr_bb), 64'(m_axis_tdata[11:9]));
				check_field("bin_count", 64'(want.bin_count), 64'(m_axis_tdata[44:12]));
				check_field("pair_total", 64'(want.pair_total), 64'(m_axis_tdata[76:45]));
				check_field("rejected", 64'(want.rejected), 64'(m_axis_tuser));
			end
		end
	end

	// Overlap vector of x over y: bit for shift 1 in the MSB; set when the low
	// SYMS-s symbols of x equal y moved down by s symbols
	function automatic logic [VEC_W-1:0] overlap_vec(input logic [WORD_W-1:0] x,
			input logic [WORD_W-1:0] y);
		logic [VEC_W-1:0]  v;
		int unsigned       keep;
		logic [WORD_W-1:0] moved;
		v     = '0;
		keep  = (1 << ((SYMS - 1) * SBITS)) - 1;
		moved = y;
		for (int s = 1; s < SYMS; s++) begin
			moved        = moved >> SBITS;
			v[VEC_W - s] = ((x ^ moved) & keep) == 0;
			keep         = keep >> SBITS;
		end
		return v;
	endfunction

	function automatic logic [BIN_W-1:0] bin_of(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] wa;
		logic [WORD_W-1:0] wb;
		wa = a & WORD_W'(WORD_MASK);
		wb = b & WORD_W'(WORD_MASK);
		return {overlap_vec(wa, wb), overlap_vec(wb, wa), overlap_vec(wa, wa),
			overlap_vec(wb, wb)};
	endfunction

	// Apply one accepted transaction to the local histogram and return its result
	function automatic outcome_t histogram_outcome(input kind_t kind,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
			input logic [INDEX_W-1:0] idx);
		outcome_t          r;
		logic [WORD_W-1:0] wa;
		logic [WORD_W-1:0] wb;
		logic [BIN_W-1:0]  bin;
		r  = '{default: '0};
		wa = a & WORD_W'(WORD_MASK);
		wb = b & WORD_W'(WORD_MASK);
		if (kind == KIND_ADD) begin
			r.corr_ab = overlap_vec(wa, wb);
			r.corr_ba = overlap_vec(wb, wa);
			r.corr_aa = overlap_vec(wa, wa);
			r.corr_bb = overlap_vec(wb, wb);
			if (wb < wa) begin
				bin = {r.corr_ab, r.corr_ba, r.corr_aa, r.corr_bb};
				if (bin_tally[bin] == '0)
					busy_bins.push_back(bin);
				// Saturate both the bin and the total
				if (bin_tally[bin] != '1)
					bin_tally[bin]++;
				if (pairs_seen != '1)
					pairs_seen++;
			end else begin
				r.rejected = 1'b1;
			end
		end else begin
			r.bin_count = {1'b0, bin_tally[idx[BIN_W-1:0]]} << 1;
		end
		r.pair_total = pairs_seen;
		return r;
	endfunction

	// Drive one input transaction, optionally after an idle burst, and wait for it to go in.
	// Valid stays high afterwards; the next call or the final drain decides its next value.
	task automatic send_item(input kind_t kind, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [INDEX_W-1:0] idx);
		int gap;
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, idx, b, a};
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		outcomes_due.push_back(histogram_outcome(kind, a, b, idx));
	endtask

	// Word with structure: random, drawn from two symbols, or periodic
	function automatic logic [WORD_W-1:0] shaped_word();
		logic [WORD_W-1:0] w;
		logic [SBITS-1:0]  pal [2];
		int                period;
		w = WORD_W'($urandom);
		case ($urandom_range(0, 3))
			2: begin
				pal[0] = SBITS'($urandom);
				pal[1] = SBITS'($urandom);
				for (int i = 0; i < SYMS; i++)
					w[i * SBITS +: SBITS] = pal[1'($urandom_range(0, 1))];
			end
			3: begin
				period = $urandom_range(1, VEC_W);
				for (int i = period; i < SYMS; i++)
					w[i * SBITS +: SBITS] = w[(i - period) * SBITS +: SBITS];
			end
			default: ;
		endcase
		return w;
	endfunction

	// Pair with a > b whose words often overlap each other
	task automatic ordered_pair(output logic [WORD_W-1:0] a, output logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] fill;
		int                sh;
		x    = shaped_word();
		fill = WORD_W'($urandom);
		sh   = SBITS * $urandom_range(1, VEC_W);
		case ($urandom_range(0, 3))
			0: y = shaped_word();
			1: y = (x >> sh) | (fill << (WORD_BITS - sh));
			2: y = (x << sh) | (fill & WORD_W'((1 << sh) - 1));
			default: y = x ^ (8'h01 << $urandom_range(0, WORD_W - 1));
		endcase
		if (x < y) begin
			a = y;
			b = x;
		end else begin
			a = x;
			b = y;
		end
		// Break a tie so that the pair still counts
		if (a == b) begin
			if (a == '0)
				a = 8'h01;
			else
				b = a - 1'b1;
		end
	endtask

	// Mostly counted pairs, some rejected pairs, reads of hit bins and of any bin
	task automatic send_mixed_item();
		int                   pick;
		logic [WORD_W-1:0]    a;
		logic [WORD_W-1:0]    b;
		logic [INDEX_W-1:0]   idx;
		a    = WORD_W'($urandom);
		b    = WORD_W'($urandom);
		idx  = INDEX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			ordered_pair(a, b);
			send_item(KIND_ADD, a, b, idx);
		end else if (pick < 72) begin
			a = shaped_word();
			b = ($urandom_range(0, 3) == 0) ? a : WORD_W'($urandom_range(a, 255));
			send_item(KIND_ADD, a, b, idx);
		end else if (pick < 92 && busy_bins.size() > 0) begin
			idx = busy_bins[$urandom_range(0, busy_bins.size() - 1)];
			send_item(KIND_READ, a, b, idx);
		end else begin
			send_item(KIND_READ, a, b, idx);
		end
	endtask

	// Extremes of the words and the bin index, rejected pairs, overlapping words, reads
	task automatic test_directed();
		send_item(KIND_READ, 8'h00, 8'h00, 12'h000);   // empty bin right after the clear
		send_item(KIND_READ, 8'hFF, 8'hFF, 12'hFFF);
		send_item(KIND_ADD, 8'hFF, 8'h00, 12'hFFF);
		send_item(KIND_ADD, 8'h00, 8'h00, 12'h000);    // equal words: rejected
		send_item(KIND_ADD, 8'h00, 8'hFF, 12'hFFF);    // b above a: rejected
		send_item(KIND_ADD, 8'hAA, 8'hAA, 12'hA5A);
		send_item(KIND_ADD, 8'h55, 8'h54, 12'h5A5);
		send_item(KIND_ADD, 8'hFF, 8'hFE, 12'h000);
		send_item(KIND_ADD, 8'h01, 8'h00, 12'h001);
		send_item(KIND_ADD, 8'h80, 8'h7F, 12'h800);
		send_item(KIND_ADD, 8'hCC, 8'h33, 12'h123);    // period-two words
		send_item(KIND_ADD, 8'hB4, 8'h2D, 12'h456);    // b is a moved down one symbol
		send_item(KIND_ADD, 8'hE4, 8'h39, 12'h789);
		send_item(KIND_ADD, 8'h1B, 8'h06, 12'hABC);
		send_item(KIND_ADD, 8'hFF, 8'h00, 12'hDEF);    // same bin again
		send_item(KIND_READ, 8'hFF, 8'h00, bin_of(8'hFF, 8'h00));
		send_item(KIND_READ, 8'h00, 8'hFF, bin_of(8'hCC, 8'h33));
		send_item(KIND_READ, 8'h55, 8'hAA, bin_of(8'hB4, 8'h2D));
		send_item(KIND_READ, 8'h00, 8'h00, bin_of(8'hAA, 8'hAA));  // rejected pair left it
		send_item(KIND_ADD, 8'hF0, 8'h0F, 12'hF0F);
		send_item(KIND_READ, 8'hAA, 8'h55, bin_of(8'hF0, 8'h0F));
		send_item(KIND_READ, 8'h00, 8'h00, 12'h7FF);
	endtask

	// Stall the output for a long stretch while input keeps coming, so the block fills
	task automatic test_output_stall();
		tx_idle_en = 1'b0;
		rx_hold    = 300;
		repeat (30) send_mixed_item();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_mixed_traffic(input int count);
		repeat (count) send_mixed_item();
	endtask

	// Back-to-back transactions with no idling on either side
	task automatic test_steady_stream(input int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (count) send_mixed_item();
	endtask

	initial begin
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		pairs_seen = '0;
		wait (arst_n === 1'b1);

		test_directed();
		test_output_stall();
		test_mixed_traffic(1000);
		test_steady_stream(300);

		// Drop valid after the last transaction, then drain the results
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
